FILE: sv/dtwp_pkg.sv
package dtwp_pkg;

  localparam int COLS         = 74;
  localparam int ROWS         = 32;
  localparam int DEPTH_LEVELS = 7;
  localparam int EDGE_STEPS   = 16;
  localparam int CELLS        = ROWS * COLS;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int K_W          = $clog2(EDGE_STEPS);

  localparam logic [14:0] EXTENT_RESET = 15'd22170;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_EDGE   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] AX_HORIZ = 2'd0;
  localparam logic [1:0] AX_VERT  = 2'd1;
  localparam logic [1:0] AX_DEPTH = 2'd2;

  function automatic logic [7:0] shade(input logic [2:0] lvl);
    logic [7:0] c;
    case (lvl)
      3'd1:    c = 8'h2E;
      3'd2:    c = 8'h3A;
      3'd3:    c = 8'h3B;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h6F;
      3'd6:    c = 8'h4F;
      3'd7:    c = 8'h30;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // truncate Q8.8 toward zero to whole units
  function automatic logic signed [7:0] trunc_unit(input logic signed [15:0] c);
    logic signed [7:0] q;
    q = c[15:8];
    if (c[15] && (c[7:0] != 8'd0)) q = q + 8'sd1;
    return q;
  endfunction

endpackage

FILE: sv/depth_tested_wireframe_plotter.sv
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata, in_tuser (opcode)
// out      out  out_tvalid/out_tready  out_tdata (char_code), out_tuser (is_vertex)
// cfg      in   cfg_tvalid/cfg_tready  cfg_tdata (extent)
// Each coordinate bin passes through S_T, S_N and S_STO, and also through S_DIV when it
// needs a divide, waiting there on one shared 9-step divider.
// Vertex: three bins, then S_RD and S_WR; edge: 15 samples, each binned and written alike;
// read: S_Q then S_OUT; each item also passes through idle before the next transfer.
// Clear and reset sweep the 2368-cell store, one cell a cycle; no input meanwhile.
// Config is taken only when idle. A result waits in the output register under stall.
module depth_tested_wireframe_plotter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // depth, horiz, vert, depth_end, horiz_end, vert_end, read_row, read_col, pad
  input  logic [111:0] in_tdata,
  // opcode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // char_code
  output logic [7:0]   out_tdata,
  // is_vertex
  output logic [0:0]   out_tuser,
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  // extent, pad
  input  logic [15:0]  cfg_tdata
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_T, S_N, S_DIV, S_STO, S_RD, S_WR, S_Q, S_OUT
  } state_t;

  localparam int AW = dtwp_pkg::ADDR_W;
  localparam int KW = dtwp_pkg::K_W;

  state_t state_r;
  logic [14:0] extent_r;
  logic [1:0]  op_r, ax_r;
  logic signed [15:0] dep_r, hor_r, ver_r, depe_r, hore_r, vere_r;
  logic [4:0]  rrow_r;
  logic [6:0]  rcol_r;
  logic [KW-1:0] k_r;
  logic [AW-1:0] clr_r;
  logic signed [21:0] t_r;
  logic [7:0]  bin_r;
  logic [6:0]  col_r;
  logic [4:0]  row_r;
  logic [2:0]  dlv_r;
  logic        oor_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_user_r;

  logic [3:0]  mem [dtwp_pkg::CELLS];
  logic [3:0]  rd_q;
  logic        mem_we;
  logic [AW-1:0] waddr, raddr, cell_addr, read_addr;
  logic [3:0]  wdata;

  logic signed [15:0] cs, ce;
  logic signed [7:0]  ta, tb;
  logic signed [8:0]  dlt;
  logic signed [12:0] xs;
  logic signed [21:0] t_nxt;
  logic [6:0]  nsel;
  logic [27:0] dividend;
  logic [19:0] divisor;
  logic        div_start, div_done;
  logic [7:0]  div_q;
  logic signed [3:0] cell_v, mark, lvl;
  logic        do_write, read_in;

  always_comb begin
    case (ax_r)
      dtwp_pkg::AX_HORIZ: begin cs = hor_r; ce = hore_r; nsel = 7'(dtwp_pkg::COLS); end
      dtwp_pkg::AX_VERT:  begin cs = ver_r; ce = vere_r; nsel = 7'(dtwp_pkg::ROWS); end
      default: begin cs = dep_r; ce = depe_r; nsel = 7'(dtwp_pkg::DEPTH_LEVELS); end
    endcase
    ta  = dtwp_pkg::trunc_unit(cs);
    tb  = dtwp_pkg::trunc_unit(ce);
    dlt = 9'(tb) - 9'(ta);
    xs  = 13'(13'(ta) * 13'sd16) + 13'(dlt * $signed({1'b0, k_r}));
    if (op_r == dtwp_pkg::OP_VERTEX)
      t_nxt = 22'(cs) + $signed({7'd0, extent_r});
    else
      t_nxt = 22'($signed({xs, 8'd0})) + $signed({3'd0, extent_r, 4'd0});
  end

  assign dividend  = 28'(nsel * t_r[20:0]) - 28'd1;
  assign divisor   = (op_r == dtwp_pkg::OP_VERTEX) ? {4'd0, extent_r, 1'b0}
                                                   : {extent_r, 5'd0};
  assign div_start = (state_r == S_N) && (t_r > 22'sd0) && (extent_r != 15'd0);

  dtwp_bin_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .limit    ({1'b0, nsel} - 8'd1),
    .done     (div_done),
    .quot     (div_q)
  );

  assign cell_addr = AW'(row_r * 7'(dtwp_pkg::COLS)) + AW'(col_r);
  assign read_in   = (32'(rrow_r) < dtwp_pkg::ROWS) && (32'(rcol_r) < dtwp_pkg::COLS);
  assign read_addr = read_in ? AW'(rrow_r * 7'(dtwp_pkg::COLS)) + AW'(rcol_r) : '0;
  assign raddr     = (state_r == S_Q || state_r == S_OUT) ? read_addr : cell_addr;

  assign cell_v = $signed(rd_q);
  assign mark = -$signed({1'b0, dlv_r}) - 4'sd1;
  assign lvl  = $signed({1'b0, dlv_r}) + 4'sd1;
  assign do_write = (op_r == dtwp_pkg::OP_VERTEX) ? (cell_v > mark)
                                                  : (!cell_v[3] && (cell_v < lvl));
  always_comb begin
    mem_we = 1'b0;
    waddr  = cell_addr;
    wdata  = 4'd0;
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      waddr  = clr_r;
    end else if (state_r == S_WR) begin
      mem_we = do_write;
      wdata  = (op_r == dtwp_pkg::OP_VERTEX) ? mark : lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) extent_r <= dtwp_pkg::EXTENT_RESET;
    else if (cfg_tvalid && cfg_tready) extent_r <= cfg_tdata[14:0];
  end
  assign cfg_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == dtwp_pkg::CELLS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r   <= in_tuser;
            dep_r  <= in_tdata[15:0];
            hor_r  <= in_tdata[31:16];
            ver_r  <= in_tdata[47:32];
            depe_r <= in_tdata[63:48];
            hore_r <= in_tdata[79:64];
            vere_r <= in_tdata[95:80];
            rrow_r <= in_tdata[100:96];
            rcol_r <= in_tdata[107:101];
            ax_r   <= dtwp_pkg::AX_HORIZ;
            k_r    <= KW'(1);
            unique case (in_tuser)
              dtwp_pkg::OP_CLEAR: begin
                clr_r   <= '0;
                state_r <= S_CLR;
              end
              dtwp_pkg::OP_READ: state_r <= S_Q;
              default:           state_r <= S_T;
            endcase
          end
        end
        S_T: begin
          t_r     <= t_nxt;
          state_r <= S_N;
        end
        S_N: begin
          if (t_r <= 22'sd0) begin
            bin_r   <= 8'd0;
            state_r <= S_STO;
          end else if (extent_r == 15'd0) begin
            bin_r   <= {1'b0, nsel} - 8'd1;
            state_r <= S_STO;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bin_r   <= div_q;
            state_r <= S_STO;
          end
        end
        S_STO: begin
          unique case (ax_r)
            dtwp_pkg::AX_HORIZ: col_r <= bin_r[6:0];
            dtwp_pkg::AX_VERT:  row_r <= bin_r[4:0];
            default:            dlv_r <= bin_r[2:0];
          endcase
          if (ax_r == dtwp_pkg::AX_DEPTH) state_r <= S_RD;
          else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_T;
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (op_r == dtwp_pkg::OP_EDGE && 32'(k_r) != dtwp_pkg::EDGE_STEPS - 1) begin
            k_r     <= k_r + KW'(1);
            ax_r    <= dtwp_pkg::AX_HORIZ;
            state_r <= S_T;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_Q: begin
          oor_r   <= !read_in;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= !oor_r && cell_v[3];
            out_data_r  <= oor_r ? dtwp_pkg::shade(3'd0)
                         : dtwp_pkg::shade(cell_v[3] ? 3'(-cell_v) : cell_v[2:0]);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready) else $error("input taken during clear");
  a_edge_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && mem_we && op_r == dtwp_pkg::OP_EDGE) |-> !wdata[3])
    else $error("edge writes a vertex mark");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider done outside wait");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_tready)) |=> out_tvalid)
    else $error("result lost");

endmodule

FILE: sv/dtwp_bin_div.sv
module dtwp_bin_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [27:0] dividend,
  input  logic [19:0] divisor,
  input  logic [7:0]  limit,
  output logic        done,
  output logic [7:0]  quot
);

  logic        busy_r, done_r;
  logic [3:0]  step_r;
  logic [27:0] rem_r, ds_r;
  logic [7:0]  q_r, lim_r, quot_r;
  logic [28:0] diff;
  logic        ge;
  logic [7:0]  qn;

  assign diff = {1'b0, rem_r} - {1'b0, ds_r};
  assign ge   = !diff[28];
  assign qn   = q_r | (ge ? (8'd1 << step_r[2:0]) : 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 4'd8;
        rem_r  <= dividend;
        ds_r   <= {divisor, 8'd0};
        q_r    <= 8'd0;
        lim_r  <= limit;
      end else if (busy_r) begin
        if (step_r == 4'd8) begin
          if (ge) begin
            quot_r <= lim_r;
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end else begin
            ds_r   <= ds_r >> 1;
            step_r <= 4'd7;
          end
        end else begin
          if (ge) rem_r <= diff[27:0];
          q_r <= qn;
          if (step_r == 4'd0) begin
            quot_r <= (qn > lim_r) ? lim_r : qn;
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end else begin
            ds_r   <= ds_r >> 1;
            step_r <= step_r - 4'd1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: tb/depth_tested_wireframe_plotter_tb.sv
module depth_tested_wireframe_plotter_tb;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] depth, horiz, vert, depth_end, horiz_end, vert_end;
    logic [4:0]         read_row;
    logic [6:0]         read_col;
  } plot_cmd_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_vertex;
  } cell_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_tvalid = 1'b0;
  logic [15:0] cfg_tdata = '0;
  logic in_tready, out_tvalid, cfg_tready;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;

  depth_tested_wireframe_plotter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  plot_cmd_t  cmd_q[$];
  cell_char_t char_q[$];
  logic signed [4:0] grid_model[dtwp_pkg::CELLS];
  logic [14:0] extent_model;
  int errors = 0;
  int reads_seen = 0;
  int cmds_sent = 0;
  int in_gap = 0;
  int out_gap = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #200000000;
    $display("depth_tested_wireframe_plotter test failed");
    $finish;
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint coord_bin(longint numer, longint scale, longint n);
    longint e, t, q;
    e = extent_model;
    t = numer + e * scale;
    if (t <= 0) return 0;
    if (e == 0) return n - 1;
    q = (n * t - 1) / (2 * e * scale);
    return (q > n - 1) ? n - 1 : q;
  endfunction

  task automatic apply_cmd(input plot_cmd_t c);
    longint col, row, lvl, da, ha, va, dd, hd, vd;
    int idx;
    cell_char_t r;
    case (c.opcode)
      dtwp_pkg::OP_CLEAR: foreach (grid_model[i]) grid_model[i] = '0;
      dtwp_pkg::OP_VERTEX: begin
        col = coord_bin(c.horiz, 1, dtwp_pkg::COLS);
        row = coord_bin(c.vert, 1, dtwp_pkg::ROWS);
        lvl = -coord_bin(c.depth, 1, dtwp_pkg::DEPTH_LEVELS) - 1;
        idx = int'(row * dtwp_pkg::COLS + col);
        if (grid_model[idx] > lvl) grid_model[idx] = 5'(lvl);
      end
      dtwp_pkg::OP_EDGE: begin
        da = c.depth / 256; ha = c.horiz / 256; va = c.vert / 256;
        dd = c.depth_end / 256 - da;
        hd = c.horiz_end / 256 - ha;
        vd = c.vert_end / 256 - va;
        for (int k = 1; k < dtwp_pkg::EDGE_STEPS; k++) begin
          col = coord_bin(256 * (ha * dtwp_pkg::EDGE_STEPS + hd * k),
                          dtwp_pkg::EDGE_STEPS, dtwp_pkg::COLS);
          row = coord_bin(256 * (va * dtwp_pkg::EDGE_STEPS + vd * k),
                          dtwp_pkg::EDGE_STEPS, dtwp_pkg::ROWS);
          lvl = coord_bin(256 * (da * dtwp_pkg::EDGE_STEPS + dd * k),
                          dtwp_pkg::EDGE_STEPS, dtwp_pkg::DEPTH_LEVELS) + 1;
          idx = int'(row * dtwp_pkg::COLS + col);
          if (grid_model[idx] >= 0 && grid_model[idx] < lvl) grid_model[idx] = 5'(lvl);
        end
      end
      default: begin
        lvl = 0;
        if (c.read_row < dtwp_pkg::ROWS && c.read_col < dtwp_pkg::COLS)
          lvl = grid_model[c.read_row * dtwp_pkg::COLS + c.read_col];
        r.is_vertex = (lvl < 0);
        r.char_code = dtwp_pkg::shade(3'((lvl < 0) ? -lvl : lvl));
        char_q.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_cmd(cmd_q.pop_front());
        cmds_sent++;
        in_gap = short_or_long_gap();
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= cmd_q[0].opcode;
          in_tdata  <= {4'd0, cmd_q[0].read_col, cmd_q[0].read_row, cmd_q[0].vert_end,
                        cmd_q[0].horiz_end, cmd_q[0].depth_end, cmd_q[0].vert,
                        cmd_q[0].horiz, cmd_q[0].depth};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_char_t exp_c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        reads_seen++;
        if (char_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_c = char_q.pop_front();
          if (out_tdata !== exp_c.char_code)
            report_mismatch($sformatf("char_code %h expected %h", out_tdata, exp_c.char_code));
          if (out_tuser[0] !== exp_c.is_vertex)
            report_mismatch($sformatf("is_vertex %b expected %b", out_tuser, exp_c.is_vertex));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_gap = short_or_long_gap();
        out_tready <= (out_gap == 0);
      end
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 28000)) - 14000);
    endcase
  endfunction

  function automatic plot_cmd_t rand_cmd(input int op);
    plot_cmd_t c;
    c.opcode = 2'(op);
    c.depth = rand_coord(); c.horiz = rand_coord(); c.vert = rand_coord();
    c.depth_end = rand_coord(); c.horiz_end = rand_coord(); c.vert_end = rand_coord();
    c.read_row = 5'($urandom);
    c.read_col = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                             : 7'($urandom_range(0, dtwp_pkg::COLS - 1));
    return c;
  endfunction

  task automatic drain_and_set_extent(input logic [14:0] e);
    wait (cmd_q.size() == 0 && !in_tvalid);
    wait (char_q.size() == 0);
    repeat (60000) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {1'b0, e};
    do @(posedge clk); while (!cfg_tready);
    extent_model = e;
    cfg_tvalid <= 1'b0;
  endtask

  task automatic push_cmd(input plot_cmd_t c);
    cmd_q.push_back(c);
  endtask

  initial begin
    plot_cmd_t c;
    logic [14:0] ext_set[5];
    ext_set = '{15'd256, 15'd32767, 15'd1000, 15'd5000, 15'd22170};
    extent_model = dtwp_pkg::EXTENT_RESET;
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, overlapping vertex and edge, reads off grid
    c = rand_cmd(dtwp_pkg::OP_VERTEX);
    c.depth = 16'sh8000; c.horiz = 16'sh8000; c.vert = 16'sh8000; push_cmd(c);
    c.depth = 16'sh7FFF; c.horiz = 16'sh7FFF; c.vert = 16'sh7FFF; push_cmd(c);
    c.depth = '0; c.horiz = '0; c.vert = '0; push_cmd(c);
    c = rand_cmd(dtwp_pkg::OP_EDGE);
    c.depth = 16'sh8000; c.horiz = 16'sh8000; c.vert = 16'sh8000;
    c.depth_end = 16'sh7FFF; c.horiz_end = 16'sh7FFF; c.vert_end = 16'sh7FFF; push_cmd(c);
    c.depth = -16'sd255; c.horiz = -16'sd257; c.vert = 16'sd255;
    c.depth_end = 16'sd300; c.horiz_end = 16'sd0; c.vert_end = -16'sd300; push_cmd(c);
    c = rand_cmd(dtwp_pkg::OP_READ);
    c.read_row = '0; c.read_col = '0; push_cmd(c);
    c.read_row = 5'(dtwp_pkg::ROWS - 1); c.read_col = 7'(dtwp_pkg::COLS - 1); push_cmd(c);
    c.read_row = 5'(dtwp_pkg::ROWS / 2); c.read_col = 7'(dtwp_pkg::COLS / 2); push_cmd(c);
    c.read_row = 5'h1F; c.read_col = 7'h7F; push_cmd(c);
    c.read_row = 5'd3; c.read_col = 7'(dtwp_pkg::COLS); push_cmd(c);
    for (int r = 0; r < 4; r++) begin
      c.read_row = 5'($urandom_range(dtwp_pkg::ROWS / 2 - 1, dtwp_pkg::ROWS / 2));
      c.read_col = 7'(dtwp_pkg::COLS / 2 - 2 + r);
      push_cmd(c);
    end
    push_cmd(rand_cmd(dtwp_pkg::OP_CLEAR));
    c.read_row = '0; c.read_col = '0; push_cmd(c);

    for (int phase = 0; phase < 5; phase++) begin
      drain_and_set_extent(ext_set[phase]);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 19))
          0: push_cmd(rand_cmd(dtwp_pkg::OP_CLEAR));
          1, 2, 3, 4, 5: push_cmd(rand_cmd(dtwp_pkg::OP_VERTEX));
          6, 7, 8, 9: push_cmd(rand_cmd(dtwp_pkg::OP_EDGE));
          default: push_cmd(rand_cmd(dtwp_pkg::OP_READ));
        endcase
      end
    end

    wait (cmd_q.size() == 0 && !in_tvalid);
    wait (char_q.size() == 0);
    repeat (3000) @(posedge clk);
    $display("sent %0d commands over 6 extent settings, checked %0d cell reads",
             cmds_sent, reads_seen);
    if (errors == 0 && char_q.size() == 0)
      $display("depth_tested_wireframe_plotter test passed");
    else
      $display("depth_tested_wireframe_plotter test failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/dtwp_pkg.sv
sv/dtwp_bin_div.sv
sv/depth_tested_wireframe_plotter.sv
tb/depth_tested_wireframe_plotter_tb.sv
